[design/lpt_pkg.sv]
package lpt_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int THR_BITS    = 12;
	localparam int TOL_BITS    = 8;
	localparam int NUM_SENSORS = 6;
	localparam int SEL_BITS    = $clog2(NUM_SENSORS);
	localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

	localparam int MAX_E       = (2 ** THR_BITS) - 1;
	localparam int W_BITS      = $clog2(NUM_SENSORS * MAX_E + 1);
	localparam int MAG_BITS    = $clog2(5 * NUM_SENSORS * MAX_E + 1);
	localparam int S_BITS      = MAG_BITS + 1;
	localparam int DEN_BITS    = $clog2(10 * NUM_SENSORS * MAX_E + 1);
	localparam int QUO_BITS    = 12;
	localparam int STEP_BITS   = $clog2(QUO_BITS);
	localparam int DEV_BITS    = 13;

	localparam logic signed [DEV_BITS-1:0] DEV_MAX = DEV_BITS'(2 ** (QUO_BITS - 1));
	localparam logic signed [DEV_BITS-1:0] DEV_MIN = -DEV_MAX;

	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam logic [1:0] REG_BLACK = 2'd0;
	localparam logic [1:0] REG_WHITE = 2'd1;
	localparam logic [1:0] REG_TOL   = 2'd2;

	localparam logic [THR_BITS-1:0] BLACK_RST = THR_BITS'(1024);
	localparam logic [THR_BITS-1:0] WHITE_RST = THR_BITS'(3072);
	localparam logic [TOL_BITS-1:0] TOL_RST   = TOL_BITS'(10);

	typedef struct packed {
		logic [THR_BITS-1:0] black_lvl;
		logic [THR_BITS-1:0] white_lvl;
		logic [TOL_BITS-1:0] lost_tolerance;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [3:0] sensor_weight(input logic [SEL_BITS-1:0] idx);
		logic signed [3:0] w;
		case (idx)
			3'd0:    w = -4'sd5;
			3'd1:    w = -4'sd3;
			3'd2:    w = -4'sd1;
			3'd3:    w = 4'sd1;
			3'd4:    w = 4'sd3;
			3'd5:    w = 4'sd5;
			default: w = 4'sd0;
		endcase
		return w;
	endfunction

endpackage

[design/lpt_if.sv]
interface lpt_in_if import lpt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_0;
	logic [SAMPLE_BITS-1:0] sample_1;
	logic [SAMPLE_BITS-1:0] sample_2;
	logic [SAMPLE_BITS-1:0] sample_3;
	logic [SAMPLE_BITS-1:0] sample_4;
	logic [SAMPLE_BITS-1:0] sample_5;

	modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
		input ready);
	modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
		output ready);
endinterface

interface lpt_out_if import lpt_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       track_seen;
	logic                       on_track;
	logic signed [DEV_BITS-1:0] deviation;
	logic                       weight_valid;

	modport source (output valid, track_seen, on_track, deviation, weight_valid, input ready);
	modport sink (input valid, track_seen, on_track, deviation, weight_valid, output ready);
endinterface

[design/lpt_regs.sv]
module lpt_regs import lpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[ADDR_BITS-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_lvl      <= BLACK_RST;
			cfg_q.white_lvl      <= WHITE_RST;
			cfg_q.lost_tolerance <= TOL_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_BLACK: cfg_q.black_lvl      <= pwdata[THR_BITS-1:0];
				REG_WHITE: cfg_q.white_lvl      <= pwdata[THR_BITS-1:0];
				REG_TOL:   cfg_q.lost_tolerance <= pwdata[TOL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BLACK: prdata = DATA_BITS'(cfg_q.black_lvl);
			REG_WHITE: prdata = DATA_BITS'(cfg_q.white_lvl);
			REG_TOL:   prdata = DATA_BITS'(cfg_q.lost_tolerance);
			default:   prdata = '0;
		endcase
	end

endmodule

[design/lpt_div.sv]
module lpt_div import lpt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MAG_BITS-1:0] mag,
	input  logic [DEN_BITS-1:0] den,
	output logic [QUO_BITS-1:0] quo,
	output div_stat_t           stat
);

	logic [DEN_BITS-1:0]  rem_q;
	logic [DEN_BITS-1:0]  den_q;
	logic [QUO_BITS-1:0]  quo_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_BITS:0]    rem_sh;
	logic [DEN_BITS:0]    rem_sub;
	logic                 fits;

	assign rem_sh  = {rem_q, 1'b0};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_BITS'(QUO_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring shift-subtract, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_BITS'(mag);
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[design/line_position_tracker_core.sv]
// line position tracker
// in_ch carries one frame of six reflectance samples, out_ch one result item
// per frame: track_seen, on_track, deviation (signed, 1/4096 units, left
// negative) and weight_valid. both use valid/ready, accepted when both high.
// thresholds and lost tolerance are written through the apb port; the user is
// to write them only while idle, as the block itself does not enforce it.
// after a frame is accepted the clamped activations accumulate one sensor a
// cycle, then the total is checked; when the weight is valid the divider forms
// the 12 quotient bits by shift-subtract, one a cycle, and hands them back;
// the output register is then loaded. the divider is skipped when the weight
// is not valid. no new frame is accepted while one is in flight.
// a new frame is taken as soon as the previous one sits in the output
// register; if the receiver stalls, the next finished result waits in the
// sequencer and in_ch.ready stays low until the output register frees.
// reset clears the lost-frame counter and loads the threshold defaults
// (black 1024, white 3072, tolerance 10); no result is pending after reset.
module line_position_tracker_core import lpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lpt_in_if.sink               in_ch,
	lpt_out_if.source            out_ch,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	cfg_t       cfg;
	div_stat_t  div_stat;

	logic [2:0]                 state_q;
	logic [SAMPLE_BITS-1:0]     samp_q [NUM_SENSORS];
	logic [SEL_BITS-1:0]        cnt_q;
	logic [W_BITS-1:0]          w_q;
	logic signed [S_BITS-1:0]   s_q;
	logic                       seen_q;
	logic                       valid_q;
	logic                       neg_q;
	logic [TOL_BITS-1:0]        lost_q;

	logic                       out_valid_q;
	logic                       out_seen_q;
	logic                       out_on_q;
	logic signed [DEV_BITS-1:0] out_dev_q;
	logic                       out_wv_q;

	logic                       in_take;
	logic                       load_out;
	logic                       span_pos;
	logic [THR_BITS-1:0]        span_u;
	logic [CMP_BITS-1:0]        s_ext;
	logic [CMP_BITS-1:0]        b_ext;
	logic [CMP_BITS-1:0]        diff;
	logic                       gt_black;
	logic [THR_BITS-1:0]        e_cur;
	logic signed [S_BITS-1:0]   e_s;
	logic signed [S_BITS-1:0]   wt_s;
	logic signed [S_BITS-1:0]   prod;
	logic [DEN_BITS-1:0]        den;
	logic                       valid_now;
	logic [S_BITS-1:0]          s_abs;
	logic [MAG_BITS-1:0]        mag;
	logic                       div_start;
	logic [QUO_BITS-1:0]        quo;
	logic signed [DEV_BITS-1:0] q_ext;
	logic signed [DEV_BITS-1:0] dev_new;

	lpt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_take     = in_ch.valid && in_ch.ready;
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// clamped activation of the sensor at the head of the shift line
	assign span_pos = cfg.white_lvl > cfg.black_lvl;
	assign span_u   = cfg.white_lvl - cfg.black_lvl;
	assign s_ext    = CMP_BITS'(samp_q[0]);
	assign b_ext    = CMP_BITS'(cfg.black_lvl);
	assign gt_black = s_ext > b_ext;
	assign diff     = s_ext - b_ext;

	always_comb begin
		if (!gt_black || !span_pos) begin
			e_cur = '0;
		end else if (diff > CMP_BITS'(span_u)) begin
			e_cur = span_u;
		end else begin
			e_cur = diff[THR_BITS-1:0];
		end
	end

	assign e_s  = $signed(S_BITS'(e_cur));
	assign wt_s = S_BITS'(sensor_weight(cnt_q));
	assign prod = e_s * wt_s;

	assign den       = DEN_BITS'({w_q, 3'b000}) + DEN_BITS'({w_q, 1'b0});
	assign valid_now = span_pos && (den > DEN_BITS'(span_u));
	assign s_abs     = s_q[S_BITS-1] ? S_BITS'(-s_q) : S_BITS'(s_q);
	assign mag       = s_abs[MAG_BITS-1:0];
	assign div_start = (state_q == ST_CHK) && valid_now;

	lpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag),
		.den    (den),
		.quo    (quo),
		.stat   (div_stat)
	);

	assign q_ext   = $signed(DEV_BITS'(quo));
	assign dev_new = !valid_q ? '0 : (neg_q ? -q_ext : q_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			lost_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SEL_BITS'(NUM_SENSORS - 1)) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (seen_q) begin
						lost_q <= '0;
					end else if (lost_q != '1) begin
						lost_q <= lost_q + 1'b1;
					end
					state_q <= valid_now ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			samp_q[0] <= in_ch.sample_0;
			samp_q[1] <= in_ch.sample_1;
			samp_q[2] <= in_ch.sample_2;
			samp_q[3] <= in_ch.sample_3;
			samp_q[4] <= in_ch.sample_4;
			samp_q[5] <= in_ch.sample_5;
			w_q       <= '0;
			s_q       <= '0;
			seen_q    <= 1'b0;
		end else if (state_q == ST_ACC) begin
			for (int k = 0; k < NUM_SENSORS - 1; k++) begin
				samp_q[k] <= samp_q[k+1];
			end
			w_q    <= w_q + W_BITS'(e_cur);
			s_q    <= s_q + prod;
			seen_q <= seen_q || gt_black;
		end
		if (state_q == ST_CHK) begin
			valid_q <= valid_now;
			neg_q   <= s_q[S_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_seen_q <= seen_q;
			out_on_q   <= lost_q < cfg.lost_tolerance;
			out_dev_q  <= dev_new;
			out_wv_q   <= valid_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.track_seen   = out_seen_q;
	assign out_ch.on_track     = out_on_q;
	assign out_ch.deviation    = out_dev_q;
	assign out_ch.weight_valid = out_wv_q;

	a_dev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.weight_valid |-> out_ch.deviation == '0)
		else $error("deviation nonzero without valid weight");

	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.deviation >= DEV_MIN && out_ch.deviation <= DEV_MAX)
		else $error("deviation out of range");

	a_seen_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && seen_q |-> lost_q == '0)
		else $error("lost counter not cleared on seen frame");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide state");

endmodule

[tb/line_position_tracker_core_tb.sv]
module line_position_tracker_core_tb import lpt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] frame_t;

	typedef struct packed {
		logic                       track_seen;
		logic                       on_track;
		logic signed [DEV_BITS-1:0] deviation;
		logic                       weight_valid;
	} track_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	lpt_in_if  in_ch();
	lpt_out_if out_ch();

	frame_t        frames_to_send[$];
	track_t        tracks_due[$];
	frame_t        cur_frame;
	track_t        want;

	logic [THR_BITS-1:0] black_thr;
	logic [THR_BITS-1:0] white_thr;
	logic [TOL_BITS-1:0] lost_tol;
	logic [7:0]          lost_run;

	int unsigned src_gap;
	int unsigned snk_gap;
	bit          idle_en;
	int          errors;
	int          frames_sent;
	int          tracks_checked;
	int          reg_writes;
	int          valid_weights;

	line_position_tracker_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// centroid of clamped activations, weights 2*i-5 tenths
	function automatic track_t locate_line(frame_t f);
		track_t r;
		int     span;
		int     e;
		int     total;
		int     moment;
		int     i;
		longint q;
		bit     seen;
		span = int'(white_thr) - int'(black_thr);
		total = 0;
		moment = 0;
		seen = 1'b0;
		for (i = 0; i < NUM_SENSORS; i++) begin
			e = int'(f[i]) - int'(black_thr);
			if (e > 0)
				seen = 1'b1;
			if (e < 0)
				e = 0;
			if (span > 0 && e > span)
				e = span;
			total += e;
			moment += (2 * i - 5) * e;
		end
		if (seen)
			lost_run = 8'd0;
		else if (lost_run != 8'hFF)
			lost_run++;
		r.track_seen = seen;
		r.on_track = lost_run < lost_tol;
		r.weight_valid = 1'b0;
		r.deviation = '0;
		if (span > 0 && 10 * total > span) begin
			r.weight_valid = 1'b1;
			q = (longint'(moment) * 4096) / (10 * longint'(total));
			r.deviation = DEV_BITS'(q);
		end
		return r;
	endfunction

	function automatic frame_t frame_of(int s0, int s1, int s2, int s3, int s4, int s5);
		frame_t f;
		f[0] = SAMPLE_BITS'(s0);
		f[1] = SAMPLE_BITS'(s1);
		f[2] = SAMPLE_BITS'(s2);
		f[3] = SAMPLE_BITS'(s3);
		f[4] = SAMPLE_BITS'(s4);
		f[5] = SAMPLE_BITS'(s5);
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int     mode;
		int     pos;
		int     wide;
		int     i;
		int     b;
		int     w;
		mode = $urandom_range(0, 9);
		pos = $urandom_range(0, NUM_SENSORS - 1);
		wide = $urandom_range(0, 1);
		b = int'(black_thr);
		w = int'(white_thr);
		for (i = 0; i < NUM_SENSORS; i++) begin
			case (mode)
				0, 1: f[i] = SAMPLE_BITS'($urandom);
				2: f[i] = SAMPLE_BITS'($urandom_range(0, b));
				3: begin
					case ($urandom_range(0, 7))
						0: f[i] = SAMPLE_BITS'(b - 1);
						1: f[i] = SAMPLE_BITS'(b);
						2: f[i] = SAMPLE_BITS'(b + 1);
						3: f[i] = SAMPLE_BITS'(w - 1);
						4: f[i] = SAMPLE_BITS'(w);
						5: f[i] = SAMPLE_BITS'(w + 1);
						6: f[i] = '0;
						default: f[i] = '1;
					endcase
				end
				4: f[i] = SAMPLE_BITS'(b + $urandom_range(0, 40));
				default: begin
					// a line under one or two neighboring sensors
					if (i == pos || (wide == 1 && i == pos + 1))
						f[i] = SAMPLE_BITS'($urandom_range(b, 4095));
					else
						f[i] = SAMPLE_BITS'($urandom_range(0, b));
				end
			endcase
		end
		return f;
	endfunction

	task automatic report_mismatch(string field, logic signed [31:0] got,
		logic signed [31:0] exp_val);
		$display("mismatch at result %0d: %s is %0d, should be %0d",
			tracks_checked, field, got, exp_val);
		errors++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DATA_BITS-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BLACK: black_thr = value[THR_BITS-1:0];
			REG_WHITE: white_thr = value[THR_BITS-1:0];
			REG_TOL:   lost_tol = value[TOL_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(int b, int w, int t);
		write_reg(REG_BLACK, DATA_BITS'(b));
		write_reg(REG_WHITE, DATA_BITS'(w));
		write_reg(REG_TOL, DATA_BITS'(t));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (frames_to_send.size() != 0 || in_ch.valid || tracks_due.size() != 0);
	endtask

	task automatic send_random(int n);
		repeat (n) frames_to_send.push_back(random_frame());
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// frame driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				tracks_due.push_back(locate_line(cur_frame));
				frames_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					in_ch.valid <= 1'b0;
				end else if (frames_to_send.size() != 0) begin
					cur_frame = frames_to_send.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.sample_0 <= cur_frame[0];
					in_ch.sample_1 <= cur_frame[1];
					in_ch.sample_2 <= cur_frame[2];
					in_ch.sample_3 <= cur_frame[3];
					in_ch.sample_4 <= cur_frame[4];
					in_ch.sample_5 <= cur_frame[5];
					if (idle_en && $urandom_range(0, 3) == 0)
						src_gap = $urandom_range(1, 10);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (tracks_due.size() == 0) begin
					report_mismatch("unexpected item, deviation", 32'(out_ch.deviation), 0);
				end else begin
					want = tracks_due.pop_front();
					if (want.weight_valid)
						valid_weights++;
					if (out_ch.track_seen !== want.track_seen)
						report_mismatch("track_seen", 32'(out_ch.track_seen),
							32'(want.track_seen));
					if (out_ch.on_track !== want.on_track)
						report_mismatch("on_track", 32'(out_ch.on_track),
							32'(want.on_track));
					if (out_ch.deviation !== want.deviation)
						report_mismatch("deviation", 32'(out_ch.deviation),
							32'(want.deviation));
					if (out_ch.weight_valid !== want.weight_valid)
						report_mismatch("weight_valid", 32'(out_ch.weight_valid),
							32'(want.weight_valid));
				end
				tracks_checked++;
			end
			if (snk_gap != 0) begin
				snk_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (idle_en && $urandom_range(0, 5) == 0)
					snk_gap = $urandom_range(1, 10);
			end
		end
	end

	initial begin
		int b;
		int w;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample_0 = '0;
		in_ch.sample_1 = '0;
		in_ch.sample_2 = '0;
		in_ch.sample_3 = '0;
		in_ch.sample_4 = '0;
		in_ch.sample_5 = '0;
		out_ch.ready = 1'b0;
		black_thr = BLACK_RST;
		white_thr = WHITE_RST;
		lost_tol = TOL_RST;
		lost_run = 8'd0;
		idle_en = 1'b1;
		errors = 0;
		frames_sent = 0;
		tracks_checked = 0;
		reg_writes = 0;
		valid_weights = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: extremes, left and right edge, low activation boundary
		frames_to_send.push_back(frame_of(4095, 4095, 4095, 4095, 4095, 4095));
		frames_to_send.push_back(frame_of(4095, 0, 0, 0, 0, 0));
		frames_to_send.push_back(frame_of(0, 0, 0, 0, 0, 4095));
		frames_to_send.push_back(frame_of(1025, 0, 0, 0, 0, 0));
		frames_to_send.push_back(frame_of(0, 0, 1228, 0, 0, 0));
		frames_to_send.push_back(frame_of(0, 0, 0, 1229, 0, 0));
		frames_to_send.push_back(frame_of(1024, 1024, 1024, 1024, 1024, 1024));
		// lost frames until on_track drops, then recover
		repeat (10) frames_to_send.push_back(frame_of(0, 0, 0, 0, 0, 0));
		frames_to_send.push_back(frame_of(0, 2000, 3000, 0, 0, 0));
		wait_drained();

		// zero tolerance, spare register, upper data bits ignored
		write_reg(REG_TOL, 32'hFFFF_FF00);
		write_reg(REG_SPARE, 32'h0000_0123);
		frames_to_send.push_back(frame_of(3000, 0, 0, 0, 0, 0));
		frames_to_send.push_back(frame_of(0, 0, 0, 0, 0, 0));
		wait_drained();

		write_reg(REG_BLACK, 32'hFFFF_F000);
		write_reg(REG_WHITE, 32'hFFFF_FFFF);
		write_reg(REG_TOL, 32'h0000_0001);
		frames_to_send.push_back(frame_of(4095, 4095, 4095, 4095, 4095, 4095));
		frames_to_send.push_back(frame_of(0, 0, 0, 1, 0, 0));
		frames_to_send.push_back(frame_of(0, 0, 0, 0, 0, 0));
		wait_drained();

		// white equal to black, then below it
		set_config(2000, 2000, 10);
		frames_to_send.push_back(frame_of(4095, 3000, 2001, 0, 0, 0));
		wait_drained();
		set_config(4095, 0, 10);
		frames_to_send.push_back(frame_of(4095, 4095, 4095, 4095, 4095, 4095));
		frames_to_send.push_back(frame_of(0, 4095, 0, 100, 0, 0));
		wait_drained();

		set_config(BLACK_RST, WHITE_RST, TOL_RST);
		send_random(20);
		wait_drained();
		send_random(10);
		wait_drained();

		repeat (4) begin
			b = $urandom_range(0, 4095);
			if ($urandom_range(0, 3) != 0)
				w = (b == 4095) ? 4095 : $urandom_range(b + 1, 4095);
			else
				w = $urandom_range(0, 4095);
			set_config(b, w, $urandom_range(0, 255));
			send_random(25);
			wait_drained();
		end

		// long lost run past counter saturation
		set_config(3000, 3500, 255);
		repeat (258)
			frames_to_send.push_back(frame_of($urandom_range(0, 3000),
				$urandom_range(0, 3000), $urandom_range(0, 3000),
				$urandom_range(0, 3000), $urandom_range(0, 3000),
				$urandom_range(0, 3000)));
		send_random(10);
		wait_drained();

		set_config(0, 4095, 255);
		send_random(20);
		wait_drained();

		idle_en = 1'b0;
		set_config(512, 3584, 3);
		send_random(30);
		wait_drained();
		repeat (30) @(posedge clk);

		$display("%0d frames sent, %0d results checked (%0d with a valid weight)",
			frames_sent, tracks_checked, valid_weights);
		$display("%0d register writes over default, extreme and random thresholds",
			reg_writes);
		if (errors == 0 && tracks_due.size() == 0)
			$display("line_position_tracker_core regression: pass");
		else
			$display("line_position_tracker_core regression: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", tracks_due.size());
		$display("line_position_tracker_core regression: fail");
		$finish;
	end

endmodule
